// ===== rtl/core/u16550_pkg.sv =====
// Shared types and constants for the 16550-style UART register model.
package u16550_pkg;

    // Request kinds
    localparam logic [1:0] KIND_READ  = 2'd0;
    localparam logic [1:0] KIND_WRITE = 2'd1;
    localparam logic [1:0] KIND_RX    = 2'd2;

    // Register byte offsets
    localparam logic [5:0] OFF_RBR   = 6'h00;
    localparam logic [5:0] OFF_IER   = 6'h04;
    localparam logic [5:0] OFF_IIR   = 6'h08;
    localparam logic [5:0] OFF_LCR   = 6'h0C;
    localparam logic [5:0] OFF_RSV10 = 6'h10;
    localparam logic [5:0] OFF_LSR   = 6'h14;
    localparam logic [5:0] OFF_RSV20 = 6'h20;

    // Field constants
    localparam int         DLAB_BIT  = 7;
    localparam int         FLAG_RX   = 0;
    localparam int         FLAG_TX   = 1;
    localparam logic [7:0] LSR_FIXED = 8'h60;
    localparam logic [7:0] IIR_RX    = 8'd4;
    localparam logic [7:0] IIR_TX    = 8'd2;
    localparam logic [7:0] IIR_NONE  = 8'd1;

    typedef struct packed {
        logic [1:0] kind;
        logic [5:0] offset;
        logic [7:0] data;
    } item_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       irq;
        logic       bad_access;
        logic       empty_read;
    } result_t;

endpackage

// ===== rtl/core/u16550_regfile.sv =====
// UART register state with the per-request decode and update logic.
module u16550_regfile
    import u16550_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  item_t   item,
    input  logic    step,
    output result_t result
);

    logic [7:0] rx_holding_reg,   rx_holding_next;
    logic [1:0] pending_reg,      pending_next;
    logic [7:0] divisor_low_reg,  divisor_low_next;
    logic [7:0] divisor_high_reg, divisor_high_next;
    logic [3:0] int_enable_reg,   int_enable_next;
    logic [7:0] line_control_reg, line_control_next;
    logic       dlab;

    assign dlab = line_control_reg[DLAB_BIT];

    always_comb
    begin
        rx_holding_next   = rx_holding_reg;
        pending_next      = pending_reg;
        divisor_low_next  = divisor_low_reg;
        divisor_high_next = divisor_high_reg;
        int_enable_next   = int_enable_reg;
        line_control_next = line_control_reg;
        result            = '0;

        unique case (item.kind)
            KIND_READ:
            begin
                unique case (item.offset)
                    OFF_RBR:
                    begin
                        if (dlab)
                        begin
                            result.read_data = divisor_low_reg;
                        end
                        else
                        begin
                            result.empty_read     = ~pending_reg[FLAG_RX];
                            result.read_data      = rx_holding_reg;
                            pending_next[FLAG_RX] = 1'b0;
                        end
                    end
                    OFF_IER:
                        result.read_data = dlab ? divisor_high_reg : {4'd0, int_enable_reg};
                    OFF_IIR:
                    begin
                        // Receive outranks transmit; reading the transmit cause clears it
                        if (pending_reg[FLAG_RX] && int_enable_reg[FLAG_RX])
                        begin
                            result.read_data = IIR_RX;
                        end
                        else if (pending_reg[FLAG_TX] && int_enable_reg[FLAG_TX])
                        begin
                            result.read_data      = IIR_TX;
                            pending_next[FLAG_TX] = 1'b0;
                        end
                        else
                        begin
                            result.read_data = IIR_NONE;
                        end
                    end
                    OFF_LCR:
                        result.read_data = line_control_reg;
                    OFF_LSR:
                        result.read_data = LSR_FIXED | {7'd0, pending_reg[FLAG_RX]};
                    default:
                        result.bad_access = 1'b1;
                endcase
            end
            KIND_WRITE:
            begin
                unique case (item.offset)
                    OFF_RBR:
                    begin
                        if (dlab)
                        begin
                            divisor_low_next = item.data;
                        end
                        else
                        begin
                            result.tx_valid       = 1'b1;
                            result.tx_byte        = item.data;
                            pending_next[FLAG_TX] = 1'b1;
                        end
                    end
                    OFF_IER:
                    begin
                        if (dlab)
                            divisor_high_next = item.data;
                        else
                            int_enable_next = item.data[3:0];
                    end
                    OFF_LCR:
                        line_control_next = item.data;
                    OFF_IIR, OFF_RSV10, OFF_RSV20:
                    begin
                    end
                    default:
                        result.bad_access = 1'b1;
                endcase
            end
            KIND_RX:
            begin
                // Overrun simply overwrites the holding byte
                rx_holding_next       = item.data;
                pending_next[FLAG_RX] = 1'b1;
            end
            default:
            begin
            end
        endcase

        result.irq = |(pending_next & int_enable_next[1:0]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_holding_reg   <= '0;
            pending_reg      <= '0;
            divisor_low_reg  <= '0;
            divisor_high_reg <= '0;
            int_enable_reg   <= '0;
            line_control_reg <= '0;
        end
        else if (step)
        begin
            rx_holding_reg   <= rx_holding_next;
            pending_reg      <= pending_next;
            divisor_low_reg  <= divisor_low_next;
            divisor_high_reg <= divisor_high_next;
            int_enable_reg   <= int_enable_next;
            line_control_reg <= line_control_next;
        end
    end

endmodule

// ===== rtl/core/uart_16550_register_model.sv =====
// Top level of the 16550-style UART register model: request and result registers.
//
// Each request is a bus read, a bus write or a byte received from the line, and
// yields exactly one result. A request lands in an input register, is decoded
// against the register state, and its result is captured in an output register
// while the state updates in the same edge. The result is valid once the request
// has moved from the input register into the output register. The block takes one
// request per cycle while out_ready stays high; a new request is accepted in the
// same cycle that the held one moves on to the output register.
// When the result is not taken, the input register holds one more request, and
// in_ready drops only once both registers are full.
module uart_16550_register_model
    import u16550_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] kind,
    input  logic [5:0] offset,
    input  logic [7:0] data,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] read_data,
    output logic       tx_valid,
    output logic [7:0] tx_byte,
    output logic       irq,
    output logic       bad_access,
    output logic       empty_read
);

    item_t   item_reg;
    logic    item_valid_reg;
    result_t result_reg;
    logic    out_valid_reg;
    result_t result_next;
    logic    advance;

    // Move the held request into the result register whenever that slot frees up
    assign advance  = item_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !item_valid_reg || advance;

    u16550_regfile u_regfile (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_reg),
        .step   (advance),
        .result (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (in_ready)
                item_valid_reg <= in_valid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers: no reset needed
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg.kind   <= kind;
            item_reg.offset <= offset;
            item_reg.data   <= data;
        end
        if (advance)
            result_reg <= result_next;
    end

    assign out_valid  = out_valid_reg;
    assign read_data  = result_reg.read_data;
    assign tx_valid   = result_reg.tx_valid;
    assign tx_byte    = result_reg.tx_byte;
    assign irq        = result_reg.irq;
    assign bad_access = result_reg.bad_access;
    assign empty_read = result_reg.empty_read;

endmodule

// ===== tb/sv/tb_top.sv =====
// Testbench for the 16550-style UART register model: directed table, random requests, predictor.
module tb_top;
    import u16550_pkg::*;

    // Kind 3 is not decoded by the block; it must leave all state alone.
    localparam logic [1:0] KIND_UNUSED  = 2'd3;
    localparam logic [7:0] IER_MASK     = 8'h0F;
    localparam logic [5:0] OFF_TOP      = 6'h3F;
    localparam int         RANDOM_COUNT = 1000;
    localparam int         TAIL_COUNT   = 150;
    localparam int         SEGMENT_LEN  = 100;
    localparam int         STALL_LIMIT  = 2000;
    localparam int         DRAIN_CYCLES = 8;
    localparam int         MAX_REPORTS  = 10;

    typedef struct {
        logic [1:0] kind;
        logic [5:0] offset;
        logic [7:0] data;
        bit         typed;
        result_t    want;
    } stim_row_t;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [1:0] kind;
    logic [5:0] offset;
    logic [7:0] data;
    logic       out_valid;
    logic       out_ready;
    logic [7:0] read_data;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       irq;
    logic       bad_access;
    logic       empty_read;

    // Shadow copy of the register file, advanced on every accepted request.
    logic [7:0] shadow_rbr;
    logic [1:0] shadow_flags;
    logic [7:0] shadow_dll;
    logic [7:0] shadow_dlm;
    logic [3:0] shadow_ier;
    logic [7:0] shadow_lcr;

    result_t    expected_results[$];
    stim_row_t  directed_rows[$];

    // Typed-in result of the request on the bus, when the table row carries one.
    bit         row_typed;
    result_t    row_want;

    int         mismatch_count;
    int         quiet_cycles;
    int         send_gap_pct;
    int         stall_pct;
    int         stall_left;

    uart_16550_register_model i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .kind       (kind),
        .offset     (offset),
        .data       (data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .read_data  (read_data),
        .tx_valid   (tx_valid),
        .tx_byte    (tx_byte),
        .irq        (irq),
        .bad_access (bad_access),
        .empty_read (empty_read)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Apply one request to the shadow registers and return the result it must produce.
    // Reads of the receive buffer and the interrupt identification register have
    // side effects on the pending flags; DLAB redirects offsets 0x00 and 0x04.
    function automatic result_t uart_register_access(input item_t req);
        result_t res;
        logic    dlab;
        res  = '0;
        dlab = shadow_lcr[DLAB_BIT];
        case (req.kind)
            KIND_READ:
            begin
                case (req.offset)
                    OFF_RBR:
                    begin
                        if (dlab)
                        begin
                            res.read_data = shadow_dll;
                        end
                        else
                        begin
                            // Empty read returns the stale byte and flags it.
                            res.empty_read = ~shadow_flags[FLAG_RX];
                            res.read_data = shadow_rbr;
                            shadow_flags[FLAG_RX] = 1'b0;
                        end
                    end
                    OFF_IER: res.read_data = dlab ? shadow_dlm : {4'h0, shadow_ier};
                    OFF_IIR:
                    begin
                        if (shadow_flags[FLAG_RX] && shadow_ier[FLAG_RX])
                        begin
                            res.read_data = IIR_RX;
                        end
                        else if (shadow_flags[FLAG_TX] && shadow_ier[FLAG_TX])
                        begin
                            res.read_data = IIR_TX;
                            shadow_flags[FLAG_TX] = 1'b0;
                        end
                        else
                        begin
                            res.read_data = IIR_NONE;
                        end
                    end
                    OFF_LCR: res.read_data = shadow_lcr;
                    OFF_LSR: res.read_data = LSR_FIXED | {7'h0, shadow_flags[FLAG_RX]};
                    default: res.bad_access = 1'b1;
                endcase
            end
            KIND_WRITE:
            begin
                case (req.offset)
                    OFF_RBR:
                    begin
                        if (dlab)
                        begin
                            shadow_dll = req.data;
                        end
                        else
                        begin
                            res.tx_valid = 1'b1;
                            res.tx_byte = req.data;
                            shadow_flags[FLAG_TX] = 1'b1;
                        end
                    end
                    OFF_IER:
                    begin
                        if (dlab)
                        begin
                            shadow_dlm = req.data;
                        end
                        else
                        begin
                            shadow_ier = 4'(req.data & IER_MASK);
                        end
                    end
                    OFF_LCR: shadow_lcr = req.data;
                    OFF_IIR, OFF_RSV10, OFF_RSV20: ;
                    default: res.bad_access = 1'b1;
                endcase
            end
            KIND_RX:
            begin
                // Overrun is silent: the new byte simply replaces the old one.
                shadow_rbr = req.data;
                shadow_flags[FLAG_RX] = 1'b1;
            end
            default: ;
        endcase
        // Only the two low enable bits gate the interrupt line.
        res.irq = |(shadow_flags & shadow_ier[1:0]);
        return res;
    endfunction

    task automatic add_row(input logic [1:0] k, input logic [5:0] o, input logic [7:0] d,
                           input bit typed = 1'b0, input result_t want = '0);
        stim_row_t row;
        row.kind   = k;
        row.offset = o;
        row.data   = d;
        row.typed  = typed;
        row.want   = want;
        directed_rows.push_back(row);
    endtask

    // Present one request at the falling edge and hold it until accepted.
    // Returns at the falling edge after acceptance with in_valid still high,
    // so a back-to-back request keeps valid up without a glitch.
    task automatic send_request(input logic [1:0] k, input logic [5:0] o,
                                input logic [7:0] d, input bit typed,
                                input result_t want, input int gap);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid  <= 1'b1;
        kind      <= k;
        offset    <= o;
        data      <= d;
        row_typed = typed;
        row_want  = want;
        do
            @(posedge clk);
        while (!(in_valid && in_ready));
        @(negedge clk);
    endtask

    // Drop valid and hold off until every outstanding result has been taken.
    task automatic drain_results();
        in_valid <= 1'b0;
        while (expected_results.size() > 0)
            @(negedge clk);
    endtask

    // Receiver: drop out_ready in random bursts whose length stall_left counts down.
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left = stall_left - 1;
            out_ready <= 1'b0;
        end
        else if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct)
        begin
            stall_left = $urandom_range(1, 19) - 1;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    // Scoreboard and watchdog. Retire the oldest expectation before queuing a
    // new one, so a result can never be matched against its own request.
    always @(posedge clk)
    begin : scoreboard
        result_t want;
        result_t got;
        result_t predicted;
        bit      moved;
        if (rst_n)
        begin
            moved = 1'b0;
            if (out_valid && out_ready)
            begin
                moved = 1'b1;
                got = '{read_data, tx_valid, tx_byte, irq, bad_access, empty_read};
                if (expected_results.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("[%0t] unexpected result rd=%02h txv=%b txb=%02h %s%b %s%b %s%b",
                                 $realtime, got.read_data, got.tx_valid, got.tx_byte,
                                 "irq=", got.irq, "bad=", got.bad_access,
                                 "empty=", got.empty_read);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got.read_data !== want.read_data || got.tx_valid !== want.tx_valid
                        || got.tx_byte !== want.tx_byte || got.irq !== want.irq
                        || got.bad_access !== want.bad_access
                        || got.empty_read !== want.empty_read)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTS)
                        begin
                            $write("[%0t] mismatch: expected rd=%02h txv=%b txb=%02h ",
                                   $realtime, want.read_data, want.tx_valid, want.tx_byte);
                            $write("irq=%b bad=%b empty=%b, ",
                                   want.irq, want.bad_access, want.empty_read);
                            $write("got rd=%02h txv=%b txb=%02h ",
                                   got.read_data, got.tx_valid, got.tx_byte);
                            $display("irq=%b bad=%b empty=%b",
                                     got.irq, got.bad_access, got.empty_read);
                        end
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                moved = 1'b1;
                // Advance the shadow state even when the table row types the result in.
                predicted = uart_register_access(item_t'{kind, offset, data});
                expected_results.push_back(row_typed ? row_want : predicted);
            end
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("[%0t] no handshake for %0d cycles, %0d results outstanding",
                         $realtime, STALL_LIMIT, expected_results.size());
                $display("** uart_16550_register_model: FAILED **");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        int         effective;
        int         r;
        int         gap;
        logic [1:0] k;
        logic [5:0] o;
        logic [7:0] d;
        logic [5:0] legal_offsets[7];

        rst_n          = 1'b0;
        in_valid       = 1'b0;
        kind           = KIND_READ;
        offset         = OFF_RBR;
        data           = 8'h00;
        out_ready      = 1'b0;
        row_typed      = 1'b0;
        row_want       = '0;
        mismatch_count = 0;
        quiet_cycles   = 0;
        send_gap_pct   = 0;
        stall_pct      = 0;
        stall_left     = 0;
        shadow_rbr     = '0;
        shadow_flags   = '0;
        shadow_dll     = '0;
        shadow_dlm     = '0;
        shadow_ier     = '0;
        shadow_lcr     = '0;
        legal_offsets  = '{OFF_RBR, OFF_IER, OFF_IIR, OFF_LCR, OFF_RSV10, OFF_LSR, OFF_RSV20};

        // Directed table. Rows with a result typed in hold values readable
        // straight from the register map; the rest go through the predictor.
        // Empty receive read straight out of reset.
        add_row(KIND_READ,  OFF_RBR,   8'h00, 1'b1, result_t'{8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 1'b1});
        add_row(KIND_READ,  OFF_IIR,   8'h00, 1'b1, result_t'{IIR_NONE, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0});
        add_row(KIND_READ,  OFF_LSR,   8'hFF, 1'b1, result_t'{LSR_FIXED, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0});
        // Undefined offsets on both read and write.
        add_row(KIND_READ,  OFF_TOP,   8'h00, 1'b1, result_t'{8'h00, 1'b0, 8'h00, 1'b0, 1'b1, 1'b0});
        add_row(KIND_WRITE, OFF_TOP,   8'hFF, 1'b1, result_t'{8'h00, 1'b0, 8'h00, 1'b0, 1'b1, 1'b0});
        add_row(KIND_READ,  OFF_RSV10, 8'h00, 1'b1, result_t'{8'h00, 1'b0, 8'h00, 1'b0, 1'b1, 1'b0});
        // Writes to reserved offsets are accepted and dropped, as is a request of the unused kind.
        add_row(KIND_WRITE, OFF_IIR,   8'hAA, 1'b1, '0);
        add_row(KIND_WRITE, OFF_RSV10, 8'h55, 1'b1, '0);
        add_row(KIND_UNUSED, OFF_TOP,  8'hFF, 1'b1, '0);
        // Enable all interrupts, then transmit to raise the line.
        add_row(KIND_WRITE, OFF_IER,   8'hFF);
        add_row(KIND_WRITE, OFF_RBR,   8'hFF, 1'b1, result_t'{8'h00, 1'b1, 8'hFF, 1'b1, 1'b0, 1'b0});
        add_row(KIND_READ,  OFF_IIR,   8'h00);
        // Receive twice: the second byte overruns the first.
        add_row(KIND_RX,    OFF_RBR,   8'h00);
        add_row(KIND_RX,    OFF_TOP,   8'hFF);
        add_row(KIND_READ,  OFF_LSR,   8'h00);
        add_row(KIND_READ,  OFF_IIR,   8'h00);
        add_row(KIND_READ,  OFF_RBR,   8'h00);
        add_row(KIND_READ,  OFF_RBR,   8'h00);
        // Divisor access under DLAB, extremes on both latches.
        add_row(KIND_WRITE, OFF_LCR,   8'h80);
        add_row(KIND_WRITE, OFF_RBR,   8'hFF);
        add_row(KIND_WRITE, OFF_IER,   8'h00);
        add_row(KIND_READ,  OFF_RBR,   8'h00);
        add_row(KIND_READ,  OFF_IER,   8'h00);
        add_row(KIND_WRITE, OFF_LCR,   8'h7F);
        add_row(KIND_READ,  OFF_LCR,   8'h00);

        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part runs with light idling on both sides.
        send_gap_pct = 20;
        stall_pct    = 10;
        foreach (directed_rows[i])
        begin
            gap = ($urandom_range(0, 99) < send_gap_pct) ? $urandom_range(1, 19) : 0;
            send_request(directed_rows[i].kind, directed_rows[i].offset, directed_rows[i].data,
                         directed_rows[i].typed, directed_rows[i].want, gap);
        end

        // Hold off until the block has returned everything it owes.
        drain_results();

        // Random part. Every segment picks its own idling mix, including none;
        // the tail runs without idling so the block sees back-to-back traffic.
        effective = 0;
        while (effective < RANDOM_COUNT)
        begin
            if (effective % SEGMENT_LEN == 0)
            begin
                r = $urandom_range(0, 2);
                send_gap_pct = (r == 0) ? 0 : (r == 1) ? 10 : 35;
                r = $urandom_range(0, 2);
                stall_pct = (r == 0) ? 0 : (r == 1) ? 8 : 30;
                if (effective == RANDOM_COUNT / 2)
                    drain_results();
            end
            if (effective >= RANDOM_COUNT - TAIL_COUNT)
            begin
                send_gap_pct = 0;
                stall_pct    = 0;
            end

            r = $urandom_range(0, 19);
            k = (r < 8) ? KIND_READ : (r < 14) ? KIND_WRITE : (r < 19) ? KIND_RX : KIND_UNUSED;
            // Mostly decoded offsets, with a share of arbitrary ones.
            o = ($urandom_range(0, 9) < 8) ? legal_offsets[$urandom_range(0, 6)]
                                           : 6'($urandom_range(0, 63));
            d = 8'($urandom_range(0, 255));
            // Keep DLAB set only about a third of the time after a control write.
            if (k == KIND_WRITE && o == OFF_LCR)
                d[DLAB_BIT] = ($urandom_range(0, 2) == 0);

            gap = ($urandom_range(0, 99) < send_gap_pct) ? $urandom_range(1, 19) : 0;
            send_request(k, o, d, 1'b0, '0, gap);

            effective++;
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (mismatch_count == 0)
            $display("** uart_16550_register_model: PASSED **");
        else
            $display("** uart_16550_register_model: FAILED **");
        $finish;
    end

endmodule
